### rtl/core/sls_pkg.sv
`default_nettype none

package sls_pkg;

    // list capacities
    localparam int MAX_TEST_STARS = 256;
    localparam int MAX_REF_STARS  = 256;
    localparam int TEST_IDX_W     = (MAX_TEST_STARS > 1) ? $clog2(MAX_TEST_STARS) : 1;
    localparam int REF_IDX_W      = (MAX_REF_STARS > 1) ? $clog2(MAX_REF_STARS) : 1;
    localparam int TEST_CNT_W     = $clog2(MAX_TEST_STARS + 1);
    localparam int REF_CNT_W      = $clog2(MAX_REF_STARS + 1);

    // shift-counter chain
    localparam int NUM_CELLS  = 16;
    localparam int CELL_IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    localparam int COORD_W = 13;   // rounded pixel coordinate, 0..4096
    localparam int SHIFT_W = 14;   // signed shifts and coordinate differences
    localparam int HIT_W   = 17;
    localparam int TOL_W   = 8;
    localparam int DIM_W   = 13;

    localparam logic [DIM_W-1:0] WIDTH_RST    = 13'd1024;
    localparam logic [DIM_W-1:0] HEIGHT_RST   = 13'd1024;
    localparam logic [TOL_W-1:0] TOL_RST      = 8'd10;
    localparam logic [HIT_W-1:0] MIN_HITS_RST = 17'd1;

    localparam logic [1:0] REQ_CLEAR    = 2'd0;
    localparam logic [1:0] REQ_LOAD_TST = 2'd1;
    localparam logic [1:0] REQ_LOAD_REF = 2'd2;
    localparam logic [1:0] REQ_SEARCH   = 2'd3;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_TOL      = 2'd2;
    localparam logic [1:0] REG_MIN_HITS = 2'd3;

    typedef logic signed [SHIFT_W-1:0] t_shift;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_star;

    // one test/reference pair moving down the chain
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic signed [SHIFT_W-1:0] pdy;
    } t_pair;

    // one dy candidate and its hit counter
    typedef struct packed {
        logic                      live;
        logic signed [SHIFT_W-1:0] dy;
        logic [HIT_W-1:0]          count;
    } t_slot;

    // floor(v + 0.5) for 12.4 fixed point
    function automatic logic [COORD_W-1:0] round_fix(input logic [15:0] v);
        logic [16:0] s;
        s = {1'b0, v} + 17'd8;
        return s[16:4];
    endfunction

    // |a - b| <= tol
    function automatic logic hit_within(input t_shift a, input t_shift b,
                                        input logic [TOL_W-1:0] tol);
        logic [SHIFT_W:0] d;
        logic [SHIFT_W:0] m;
        d = {a[SHIFT_W-1], a} - {b[SHIFT_W-1], b};
        m = d[SHIFT_W] ? (~d + 1'b1) : d;
        return m <= {{(SHIFT_W + 1 - TOL_W){1'b0}}, tol};
    endfunction

endpackage

`default_nettype wire

### rtl/core/sls_cell.sv
`default_nettype none

module sls_cell import sls_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_shift,
    input  wire logic [TOL_W-1:0] i_tol,
    input  wire t_pair            i_pair,
    input  wire t_slot            i_slot,
    output t_pair                 o_pair,
    output t_slot                 o_slot
);

    t_pair r_pair;
    t_slot r_slot;
    logic  w_hit;

    assign w_hit = i_pair.valid && hit_within(r_slot.dy, i_pair.pdy, i_tol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair <= '0;
        end else begin
            r_pair <= i_pair;
        end
    end

    // shift mode drains the counter and loads the next dy; else count hits
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_slot <= i_slot;
        end else if (w_hit && (r_slot.count != {HIT_W{1'b1}})) begin
            r_slot.count <= r_slot.count + HIT_W'(1);
        end
    end

    assign o_pair = r_pair;
    assign o_slot = r_slot;

endmodule

`default_nettype wire

### rtl/core/sls_pair_src.sv
`default_nettype none

module sls_pair_src import sls_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic             i_load_test,
    input  wire logic             i_load_ref,
    input  wire logic [15:0]      i_x,
    input  wire logic [15:0]      i_y,
    input  wire logic             i_start,
    input  wire t_shift           i_dx,
    input  wire logic [TOL_W-1:0] i_tol,
    output t_pair                 o_pair
);

    t_star r_test_mem [MAX_TEST_STARS];
    t_star r_ref_mem  [MAX_REF_STARS];

    logic [TEST_CNT_W-1:0] r_test_cnt;
    logic [REF_CNT_W-1:0]  r_ref_cnt;
    logic [TEST_IDX_W-1:0] r_s;
    logic [REF_IDX_W-1:0]  r_g;
    logic                  r_issue;
    logic                  r_empty;
    logic                  r_v1;
    logic                  r_l1;
    t_star                 r_test_rd;
    t_star                 r_ref_rd;
    t_pair                 r_pair;

    t_star  w_star;
    logic   w_test_full;
    logic   w_ref_full;
    logic   w_s_last;
    logic   w_g_last;
    logic   w_last;
    t_shift w_dx_diff;
    t_shift w_dy_diff;
    logic   w_xhit;

    assign w_star      = '{x: round_fix(i_x), y: round_fix(i_y)};
    assign w_test_full = (r_test_cnt == TEST_CNT_W'(MAX_TEST_STARS));
    assign w_ref_full  = (r_ref_cnt == REF_CNT_W'(MAX_REF_STARS));
    assign w_s_last    = ((TEST_CNT_W'(r_s) + TEST_CNT_W'(1)) == r_test_cnt);
    assign w_g_last    = ((REF_CNT_W'(r_g) + REF_CNT_W'(1)) == r_ref_cnt);
    // an empty list still sends one bubble so the end marker goes down the chain
    assign w_last      = r_empty || (w_s_last && w_g_last);

    assign w_dx_diff = $signed({1'b0, r_ref_rd.x}) - $signed({1'b0, r_test_rd.x});
    assign w_dy_diff = $signed({1'b0, r_ref_rd.y}) - $signed({1'b0, r_test_rd.y});
    assign w_xhit    = hit_within(i_dx, w_dx_diff, i_tol);

    always_ff @(posedge i_clk) begin
        if (i_load_test && !w_test_full) begin
            r_test_mem[r_test_cnt[TEST_IDX_W-1:0]] <= w_star;
        end
        r_test_rd <= r_test_mem[r_s];
    end

    always_ff @(posedge i_clk) begin
        if (i_load_ref && !w_ref_full) begin
            r_ref_mem[r_ref_cnt[REF_IDX_W-1:0]] <= w_star;
        end
        r_ref_rd <= r_ref_mem[r_g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_cnt <= '0;
            r_ref_cnt  <= '0;
            r_s        <= '0;
            r_g        <= '0;
            r_issue    <= 1'b0;
            r_empty    <= 1'b0;
            r_v1       <= 1'b0;
            r_l1       <= 1'b0;
            r_pair     <= '0;
        end else begin
            if (i_clear) begin
                r_test_cnt <= '0;
                r_ref_cnt  <= '0;
            end else begin
                if (i_load_test && !w_test_full) begin
                    r_test_cnt <= r_test_cnt + TEST_CNT_W'(1);
                end
                if (i_load_ref && !w_ref_full) begin
                    r_ref_cnt <= r_ref_cnt + REF_CNT_W'(1);
                end
            end

            if (i_start) begin
                r_issue <= 1'b1;
                r_s     <= '0;
                r_g     <= '0;
                r_empty <= (r_test_cnt == '0) || (r_ref_cnt == '0);
            end else if (r_issue) begin
                if (w_last) begin
                    r_issue <= 1'b0;
                end
                if (w_g_last) begin
                    r_g <= '0;
                    r_s <= r_s + TEST_IDX_W'(1);
                end else begin
                    r_g <= r_g + REF_IDX_W'(1);
                end
            end

            r_v1        <= r_issue && !r_empty;
            r_l1        <= r_issue && w_last;
            r_pair.valid <= r_v1 && w_xhit;
            r_pair.last  <= r_l1;
            r_pair.pdy   <= w_dy_diff;
        end
    end

    assign o_pair = r_pair;

endmodule

`default_nettype wire

### rtl/core/star_list_shift_search_top.sv
// Clear and load items are taken only in the idle state; there one star per cycle is accepted.
// A search sweeps the shifts on both axes, fed by the pair stream (one test/reference
// pair per cycle) into the counter chain.
// Synchronous active-low reset clears the list counts, the control and the
// registers to their defaults; the star stores hold no reset value.
`default_nettype none

module star_list_shift_search_top import sls_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,

    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [15:0]        i_x_coord,
    input  wire logic [15:0]        i_y_coord,

    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [HIT_W-1:0]        o_best_hits,
    output logic signed [12:0]      o_best_dx,
    output logic signed [12:0]      o_best_dy,
    output logic                    o_enough_hits,
    output logic                    o_broad_peak
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SHIFT  = 5'b00010,
        ST_STREAM = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    t_state                r_state;
    logic [DIM_W-1:0]      r_width;
    logic [DIM_W-1:0]      r_height;
    logic [TOL_W-1:0]      r_tol;
    logic [HIT_W-1:0]      r_min_hits;
    t_shift                r_dx;
    t_shift                r_dy_feed;
    t_shift                r_drain_dx;
    logic                  r_chain_live;
    logic                  r_src_start;
    logic [CELL_IDX_W-1:0] r_shift_cnt;
    logic [HIT_W-1:0]      r_best;
    logic [HIT_W-1:0]      r_prev;
    logic [1:0]            r_imp;
    t_shift                r_best_dx;
    t_shift                r_best_dy;
    logic                  r_out_valid;
    logic [HIT_W-1:0]      r_out_hits;
    logic signed [12:0]    r_out_dx;
    logic signed [12:0]    r_out_dy;
    logic                  r_out_enough;
    logic                  r_out_broad;

    logic             w_accept;
    logic             w_cfg_wr;
    logic [TOL_W-1:0] w_step;
    t_shift           w_hw;
    t_shift           w_hh;
    t_shift           w_dx_next;
    t_shift           w_dy_next;
    logic             w_shift;
    logic             w_shift_last;
    logic             w_better;
    t_pair            w_src_pair;
    t_slot            w_feed;
    t_pair            w_cell_pair [NUM_CELLS];
    t_slot            w_cell_slot [NUM_CELLS];
    t_pair            w_end_pair;
    t_slot            w_end_slot;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:    prdata = {19'd0, r_width};
            REG_HEIGHT:   prdata = {19'd0, r_height};
            REG_TOL:      prdata = {24'd0, r_tol};
            REG_MIN_HITS: prdata = {15'd0, r_min_hits};
            default:      prdata = '0;
        endcase
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    assign w_step    = (r_tol < 8'd2) ? 8'd1 : (r_tol - 8'd1);
    assign w_hw      = $signed({2'b00, r_width[DIM_W-1:1]});
    assign w_hh      = $signed({2'b00, r_height[DIM_W-1:1]});
    assign w_dx_next = r_dx + $signed({6'd0, w_step});
    assign w_dy_next = r_dy_feed + $signed({6'd0, w_step});

    assign w_shift      = (r_state == ST_SHIFT) || (r_state == ST_DRAIN);
    assign w_shift_last = (r_shift_cnt == CELL_IDX_W'(NUM_CELLS - 1));

    // dy values enter cell 0 in ascending order, so they leave the far end ascending
    assign w_feed.live  = (r_state == ST_SHIFT) && (r_dy_feed <= w_hh);
    assign w_feed.dy    = r_dy_feed;
    assign w_feed.count = '0;

    sls_pair_src u_src (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_accept && (i_req_type == REQ_CLEAR)),
        .i_load_test (w_accept && (i_req_type == REQ_LOAD_TST)),
        .i_load_ref  (w_accept && (i_req_type == REQ_LOAD_REF)),
        .i_x         (i_x_coord),
        .i_y         (i_y_coord),
        .i_start     (r_src_start),
        .i_dx        (r_dx),
        .i_tol       (r_tol),
        .o_pair      (w_src_pair)
    );

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        if (i == 0) begin : g_head
            sls_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_tol   (r_tol),
                .i_pair  (w_src_pair),
                .i_slot  (w_feed),
                .o_pair  (w_cell_pair[i]),
                .o_slot  (w_cell_slot[i])
            );
        end else begin : g_body
            sls_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_tol   (r_tol),
                .i_pair  (w_cell_pair[i-1]),
                .i_slot  (w_cell_slot[i-1]),
                .o_pair  (w_cell_pair[i]),
                .o_slot  (w_cell_slot[i])
            );
        end
    end

    assign w_end_pair = w_cell_pair[NUM_CELLS-1];
    assign w_end_slot = w_cell_slot[NUM_CELLS-1];

    // ties go to the later shift
    assign w_better = w_shift && r_chain_live && w_end_slot.live
                   && (w_end_slot.count >= r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_width      <= WIDTH_RST;
            r_height     <= HEIGHT_RST;
            r_tol        <= TOL_RST;
            r_min_hits   <= MIN_HITS_RST;
            r_dx         <= '0;
            r_dy_feed    <= '0;
            r_drain_dx   <= '0;
            r_chain_live <= 1'b0;
            r_src_start  <= 1'b0;
            r_shift_cnt  <= '0;
            r_best       <= '0;
            r_prev       <= '0;
            r_imp        <= '0;
            r_best_dx    <= '0;
            r_best_dy    <= '0;
            r_out_valid  <= 1'b0;
            r_out_hits   <= '0;
            r_out_dx     <= '0;
            r_out_dy     <= '0;
            r_out_enough <= 1'b0;
            r_out_broad  <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    REG_WIDTH:    r_width    <= pwdata[DIM_W-1:0];
                    REG_HEIGHT:   r_height   <= pwdata[DIM_W-1:0];
                    REG_TOL:      r_tol      <= pwdata[TOL_W-1:0];
                    REG_MIN_HITS: r_min_hits <= pwdata[HIT_W-1:0];
                    default:      ;
                endcase
            end

            r_src_start <= 1'b0;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_req_type == REQ_SEARCH)) begin
                        r_dx         <= -w_hw;
                        r_dy_feed    <= -w_hh;
                        r_chain_live <= 1'b0;
                        r_shift_cnt  <= '0;
                        r_best       <= '0;
                        r_prev       <= '0;
                        r_imp        <= '0;
                        r_best_dx    <= -w_hw;
                        r_best_dy    <= -w_hh;
                        r_state      <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    if (w_feed.live) begin
                        r_dy_feed <= w_dy_next;
                    end
                    r_shift_cnt <= r_shift_cnt + CELL_IDX_W'(1);
                    if (w_shift_last) begin
                        r_shift_cnt  <= '0;
                        r_chain_live <= 1'b1;
                        r_drain_dx   <= r_dx;
                        r_src_start  <= 1'b1;
                        r_state      <= ST_STREAM;
                    end
                end
                ST_STREAM: begin
                    if (w_end_pair.last) begin
                        if (r_dy_feed <= w_hh) begin
                            r_state <= ST_SHIFT;
                        end else if (w_dx_next <= w_hw) begin
                            r_dx      <= w_dx_next;
                            r_dy_feed <= -w_hh;
                            r_state   <= ST_SHIFT;
                        end else begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    r_shift_cnt <= r_shift_cnt + CELL_IDX_W'(1);
                    if (w_shift_last) begin
                        r_shift_cnt <= '0;
                        r_state     <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_hits   <= r_best;
                        r_out_dx     <= r_best_dx[12:0];
                        r_out_dy     <= r_best_dy[12:0];
                        r_out_enough <= (r_best >= r_min_hits);
                        r_out_broad  <= (r_imp < 2'd2) || (r_prev == r_best);
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_better) begin
                r_prev    <= r_best;
                r_best    <= w_end_slot.count;
                r_best_dx <= r_drain_dx;
                r_best_dy <= w_end_slot.dy;
                if (r_imp < 2'd2) begin
                    r_imp <= r_imp + 2'd1;
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_best_hits   = r_out_hits;
    assign o_best_dx     = r_out_dx;
    assign o_best_dy     = r_out_dy;
    assign o_enough_hits = r_out_enough;
    assign o_broad_peak  = r_out_broad;

`ifndef SYNTHESIS
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result posted outside of search completion");

    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) && $past(r_state != ST_IDLE) |-> r_best >= $past(r_best))
        else $error("best count dropped during a search");

    a_prev_below_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev <= r_best)
        else $error("previous peak above best count");

    a_end_marker_in_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_pair.last |-> r_state == ST_STREAM)
        else $error("pair stream end seen outside of streaming");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_star_list_shift_search_top.sv
`timescale 1ns / 1ps

module tb_star_list_shift_search_top;
    import sls_pkg::*;

    typedef struct {
        logic [HIT_W-1:0] hits;
        logic [12:0]      dx;
        logic [12:0]      dy;
        logic             enough;
        logic             broad;
    } fit_t;

    // Holds both star lists and the registers, predicts the registration
    // for every search item and checks the results in order.
    class registration_board;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned tol_reg;
        int unsigned min_hits_reg;
        logic [15:0] tst_x [MAX_TEST_STARS];
        logic [15:0] tst_y [MAX_TEST_STARS];
        logic [15:0] ref_x [MAX_REF_STARS];
        logic [15:0] ref_y [MAX_REF_STARS];
        int unsigned n_tst;
        int unsigned n_ref;
        fit_t        expected_fits[$];
        int unsigned fails;

        function new();
            width_reg    = WIDTH_RST;
            height_reg   = HEIGHT_RST;
            tol_reg      = TOL_RST;
            min_hits_reg = MIN_HITS_RST;
            n_tst        = 0;
            n_ref        = 0;
            fails        = 0;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [31:0] val);
            case (idx)
                REG_WIDTH:    width_reg    = val[12:0];
                REG_HEIGHT:   height_reg   = val[12:0];
                REG_TOL:      tol_reg      = val[7:0];
                REG_MIN_HITS: min_hits_reg = val[16:0];
                default: ;
            endcase
        endfunction

        function int round_px(input logic [15:0] v);
            int t;
            t = v;
            return (t + 8) >>> 4;
        endfunction

        function bit near(input int shift, input int diff, input int tol);
            int d;
            d = shift - diff;
            if (d < 0)
                d = -d;
            return d <= tol;
        endfunction

        // sweep every (dx, dy) shift; the last shift with the top count wins
        function fit_t best_shift();
            int          tol, stp, hw, hh, dx, dy, bdx, bdy, sxr, syr, s, g, k;
            int unsigned best, prev, improves, hits;
            int          pair_dy[$];
            fit_t        f;
            tol = tol_reg;
            stp = (tol - 1 < 1) ? 1 : tol - 1;
            hw = width_reg / 2;
            hh = height_reg / 2;
            best = 0;
            prev = 0;
            improves = 0;
            bdx = -hw;
            bdy = -hh;
            for (dx = -hw; dx <= hw; dx += stp) begin
                pair_dy.delete();
                for (s = 0; s < n_tst; s++) begin
                    sxr = round_px(tst_x[s]);
                    syr = round_px(tst_y[s]);
                    for (g = 0; g < n_ref; g++) begin
                        if (near(dx, round_px(ref_x[g]) - sxr, tol))
                            pair_dy.push_back(round_px(ref_y[g]) - syr);
                    end
                end
                for (dy = -hh; dy <= hh; dy += stp) begin
                    hits = 0;
                    for (k = 0; k < pair_dy.size(); k++) begin
                        if (near(dy, pair_dy[k], tol) && hits < 131071)
                            hits++;
                    end
                    if (hits >= best) begin
                        prev = best;
                        best = hits;
                        bdx = dx;
                        bdy = dy;
                        if (improves < 2)
                            improves++;
                    end
                end
            end
            f.hits   = best[HIT_W-1:0];
            f.dx     = bdx[12:0];
            f.dy     = bdy[12:0];
            f.enough = (best >= min_hits_reg);
            f.broad  = (improves < 2) || (prev == best);
            return f;
        endfunction

        function void note_item(input logic [1:0] req, input logic [15:0] x,
                                input logic [15:0] y);
            case (req)
                REQ_CLEAR: begin
                    n_tst = 0;
                    n_ref = 0;
                end
                REQ_LOAD_TST: begin
                    if (n_tst < MAX_TEST_STARS) begin
                        tst_x[n_tst] = x;
                        tst_y[n_tst] = y;
                        n_tst++;
                    end
                end
                REQ_LOAD_REF: begin
                    if (n_ref < MAX_REF_STARS) begin
                        ref_x[n_ref] = x;
                        ref_y[n_ref] = y;
                        n_ref++;
                    end
                end
                default: expected_fits.push_back(best_shift());
            endcase
        endfunction

        function void mismatch(input string what, input int want, input int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
                fails++;
            end
        endfunction

        function void check_fit(input logic [HIT_W-1:0] hits, input logic [12:0] dx,
                                input logic [12:0] dy, input logic enough,
                                input logic broad);
            fit_t want;
            if (expected_fits.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hits %0d dx %0d dy %0d",
                         $time, hits, $signed(dx), $signed(dy));
                fails++;
                return;
            end
            want = expected_fits.pop_front();
            mismatch("best_hits", want.hits, hits);
            mismatch("best_dx", $signed(want.dx), $signed(dx));
            mismatch("best_dy", $signed(want.dy), $signed(dy));
            mismatch("enough_hits", want.enough, enough);
            mismatch("broad_peak", want.broad, broad);
        endfunction

        function int pending();
            return expected_fits.size();
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [3:0]         paddr      = '0;
    logic [31:0]        pwdata     = '0;
    logic               i_valid    = 1'b0;
    logic [1:0]         i_req_type = REQ_CLEAR;
    logic [15:0]        i_x_coord  = '0;
    logic [15:0]        i_y_coord  = '0;
    logic               i_ready    = 1'b0;
    wire  [31:0]        prdata;
    wire                pready;
    wire                o_ready;
    wire                o_valid;
    wire  [HIT_W-1:0]   o_best_hits;
    wire  [12:0]        o_best_dx;
    wire  [12:0]        o_best_dy;
    wire                o_enough_hits;
    wire                o_broad_peak;

    registration_board board = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int items_sent    = 0;

    star_list_shift_search_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_best_hits  (o_best_hits),
        .o_best_dx    (o_best_dx),
        .o_best_dy    (o_best_dy),
        .o_enough_hits(o_enough_hits),
        .o_broad_peak (o_broad_peak)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                board.note_item(i_req_type, i_x_coord, i_y_coord);
            if (o_valid && i_ready)
                board.check_fit(o_best_hits, o_best_dx, o_best_dy, o_enough_hits,
                                o_broad_peak);
        end
    end

    // result side: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #200_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [15:0] clip16(input int v);
        if (v < 0)
            return 16'h0000;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    task automatic send_item(input logic [1:0] req, input logic [15:0] x,
                             input logic [15:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_x_coord  <= x;
        i_y_coord  <= y;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // stop offering items until every search result is back
    task automatic drain(input int settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        board.set_reg(idx, val);
    endtask

    task automatic setup(input int w, input int h, input int tol, input int mh);
        drain(40);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_TOL, tol);
        write_reg(REG_MIN_HITS, mh);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 48; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 48; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
        endcase
    endtask

    // optional clear, a few test stars, reference stars mostly copied from
    // them at one common shift with jitter, then a search
    task automatic send_star_sequence(input int xspan, input int yspan);
        int tx[6];
        int ty[6];
        int nt, nr, bx, by, ox, oy, jx, jy, k, j;
        if ($urandom_range(3) != 0)
            send_item(REQ_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535));
        nt = $urandom_range(0, 6);
        nr = $urandom_range(0, 6);
        bx = $urandom_range(0, 65535);
        by = $urandom_range(0, 65535);
        ox = $urandom_range(0, 2 * xspan);
        ox = ox - xspan;
        oy = $urandom_range(0, 2 * yspan);
        oy = oy - yspan;
        for (k = 0; k < nt; k++) begin
            tx[k] = clip16(bx + $urandom_range(0, 1024));
            ty[k] = clip16(by + $urandom_range(0, 1024));
            send_item(REQ_LOAD_TST, tx[k], ty[k]);
        end
        for (j = 0; j < nr; j++) begin
            if (nt > 0 && $urandom_range(3) != 0) begin
                k = $urandom_range(0, nt - 1);
                jx = $urandom_range(0, 64);
                jy = $urandom_range(0, 64);
                send_item(REQ_LOAD_REF, clip16(tx[k] + ox * 16 + jx - 32),
                          clip16(ty[k] + oy * 16 + jy - 32));
            end else begin
                send_item(REQ_LOAD_REF, $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
        end
        // now and then a broken sequence: no search, or stray items
        if ($urandom_range(9) != 0)
            send_item(REQ_SEARCH, $urandom_range(0, 65535), $urandom_range(0, 65535));
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 3))
                send_item($urandom_range(0, 3), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
        end
    endtask

    initial begin
        int ph, first_item, w, h, k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers, empty lists
        send_item(REQ_SEARCH, 16'hA5A5, 16'h5A5A);

        // single shift, coordinate extremes and the rounding edge
        setup(0, 1, 255, 0);
        send_item(REQ_LOAD_TST, 16'h0000, 16'h0000);
        send_item(REQ_LOAD_TST, 16'hFFFF, 16'hFFFF);
        send_item(REQ_LOAD_TST, 16'h0008, 16'h0007);
        send_item(REQ_LOAD_REF, 16'h0000, 16'h0000);
        send_item(REQ_LOAD_REF, 16'hFFFF, 16'hFFFF);
        send_item(REQ_LOAD_REF, 16'h0017, 16'h0018);
        send_item(REQ_SEARCH, 16'hFFFF, 16'h0000);

        // largest image, unreachable minimum
        setup(4096, 4096, 255, 65536);
        send_item(REQ_SEARCH, 16'h0000, 16'hFFFF);

        // tolerance one: step stays at one
        setup(8, 8, 1, 1);
        send_item(REQ_CLEAR, 16'h1234, 16'h4321);
        send_item(REQ_LOAD_TST, 16'h0018, 16'h0028);
        send_item(REQ_LOAD_REF, 16'h0037, 16'h0048);
        send_item(REQ_LOAD_REF, 16'h0018, 16'h0028);
        send_item(REQ_SEARCH, 16'h0000, 16'h0000);
        send_item(REQ_CLEAR, 16'hFFFF, 16'hFFFF);
        send_item(REQ_SEARCH, 16'h0000, 16'h0000);

        // tolerance zero: exact matches only
        setup(6, 12, 0, 2);
        send_item(REQ_LOAD_TST, 16'h0100, 16'h0100);
        send_item(REQ_LOAD_TST, 16'h0100, 16'h0100);
        send_item(REQ_LOAD_REF, 16'h0120, 16'h00F0);
        send_item(REQ_SEARCH, 16'h0000, 16'h0000);

        for (ph = 0; ph < 8; ph++) begin
            set_idling(ph % 4);
            if (ph == 1) begin
                // overfill both lists, tiny sweep
                setup(1, 2, 3, $urandom_range(0, 300));
                send_item(REQ_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535));
                for (k = 0; k < MAX_TEST_STARS + 6; k++)
                    send_item(REQ_LOAD_TST, $urandom_range(0, 320), $urandom_range(0, 320));
                for (k = 0; k < MAX_REF_STARS + 6; k++)
                    send_item(REQ_LOAD_REF, $urandom_range(0, 320), $urandom_range(0, 320));
                send_item(REQ_SEARCH, $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
            if (ph == 6) begin
                // hold results back while searches keep coming
                setup(16, 16, 8, 1);
                send_item(REQ_CLEAR, 16'h0000, 16'h0000);
                for (k = 0; k < 3; k++) begin
                    send_item(REQ_LOAD_TST, 16'h2000 + 16 * k, 16'h3000);
                    send_item(REQ_LOAD_REF, 16'h2040 + 16 * k, 16'h2FC0);
                end
                hold_left = 3000;
                repeat (6)
                    send_item(REQ_SEARCH, $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else begin
                w = $urandom_range(8, 160);
                h = $urandom_range(8, 160);
                case ($urandom_range(3))
                    0: setup(w, h, $urandom_range(6, 40), 0);
                    1: setup(w, h, $urandom_range(6, 40), $urandom_range(1, 4));
                    2: setup(w, h, $urandom_range(6, 40), 65536);
                    default: setup(w, h, $urandom_range(6, 40), $urandom_range(1, 36));
                endcase
            end
            first_item = items_sent;
            while (items_sent - first_item < 170) begin
                send_star_sequence(board.width_reg / 2, board.height_reg / 2);
                if (ph == 3 && items_sent - first_item >= 85 && items_sent - first_item < 95)
                    drain(1);
            end
        end

        drain(60);
        if (board.fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
